FILE: rtl/core/glob_wildcard_matcher_assert.svh
// Assertion macros for the glob wildcard matcher.
`ifndef GLOB_WILDCARD_MATCHER_ASSERT_SVH
`define GLOB_WILDCARD_MATCHER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define GWM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define GWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GWM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define GWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/gwm_pkg.sv
// Shared types and constants of the glob wildcard matcher.
package gwm_pkg;

  localparam int PATTERN_MAX_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] SYM_ANY_ONE = 8'h3F;
  localparam logic [7:0] SYM_ANY_RUN = 8'h2A;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_TEXT   = 2'd2;
  localparam logic [1:0] MODE_END    = 2'd3;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_TEXT,
    OP_END
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] code;
    logic       is_star;
    logic       is_any;
  } cmd_t;

endpackage

FILE: rtl/core/glob_wildcard_matcher.sv
// Glob wildcard matcher: usage and timing notes.
// Input channel (in_valid/in_stall) carries mode and char_code. Mode clear
// empties the pattern, append adds one pattern byte, text streams one text
// byte, end of text yields one result transfer on the output channel
// (out_valid/out_stall) with matched and overflow. '?' matches any one byte,
// '*' matches any run including an empty one.
// Throughput: one item per cycle while in_stall is low; every pattern position is stepped in
// parallel on each text byte, through a log-depth closure over '*' runs.
// An input transfer is written into a two-entry command queue, from which the
// back end takes it; an end-of-text result is registered and shows on out_valid
// in the cycle after the back end takes it.
// A stalled result holds in the output register while the back end keeps
// executing clear, append and text commands; only a further end-of-text
// waits for the register. in_stall rises when the queue is full.
// Reset (rst, synchronous, active high) empties the queue and the pattern,
// clears the overflow flag and leaves only position zero active.
// Appends beyond PATTERN_MAX bytes are dropped and set overflow.
`include "glob_wildcard_matcher_assert.svh"
module glob_wildcard_matcher #(
  parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic       overflow
);
  import gwm_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  gwm_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .char_code (char_code),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  gwm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  gwm_back #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .matched   (matched),
    .overflow  (overflow)
  );

  `GWM_ASSERT_NOW(a_ovf_forces_miss, clk, rst, out_valid && overflow, !matched, "overflow result reports a match")
  `GWM_ASSERT_NEXT(a_end_gives_result, clk, rst, q_pop && (q_cmd.op == OP_END), out_valid, "end of text gave no result")
  `GWM_ASSERT_NEXT(a_transfer_queued, clk, rst, in_valid && !in_stall, q_valid, "accepted transfer missing from queue")

endmodule

FILE: rtl/core/gwm_front.sv
// Front end: accepts input transfers and classifies them into commands.
module gwm_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    mode,
  input  logic [7:0]    char_code,
  input  logic          q_full,
  output logic          q_push,
  output gwm_pkg::cmd_t q_cmd
);
  import gwm_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    case (mode)
      MODE_CLEAR:  q_cmd.op = OP_CLEAR;
      MODE_APPEND: q_cmd.op = OP_APPEND;
      MODE_TEXT:   q_cmd.op = OP_TEXT;
      MODE_END:    q_cmd.op = OP_END;
      default:     q_cmd.op = OP_END;
    endcase
    q_cmd.code    = char_code;
    q_cmd.is_star = (char_code == SYM_ANY_RUN);
    q_cmd.is_any  = (char_code == SYM_ANY_ONE);
  end

endmodule

FILE: rtl/core/gwm_queue.sv
// Short command queue between the front end and the back end.
module gwm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gwm_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output gwm_pkg::cmd_t q_cmd
);
  import gwm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
    bump = (ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

FILE: rtl/core/gwm_back.sv
// Back end: pattern cells, active position vector and result register.
module gwm_back #(
  parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  gwm_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          matched,
  output logic          overflow
);
  import gwm_pkg::*;

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LV = $clog2(PATTERN_MAX + 1);

  logic [7:0]             byte_store [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] star_bits;
  logic [PATTERN_MAX-1:0] any_bits;
  logic [PATTERN_MAX-1:0] vmask;
  logic [LW-1:0]          pat_len;
  logic                   ovf;
  logic [PATTERN_MAX:0]   active;
  logic [PATTERN_MAX:0]   restart_vec;
  logic [PATTERN_MAX:0]   restart_vec_next;
  logic [PATTERN_MAX:0]   advanced;
  logic [PATTERN_MAX-1:0] keep_bits;
  logic [PATTERN_MAX-1:0] move_bits;
  logic [LV:0][PATTERN_MAX:0] gen_v;
  logic [LV:0][PATTERN_MAX:0] prop_v;
  logic                   room;
  logic                   hit;

  assign q_pop = q_valid && ((q_cmd.op != OP_END) || !out_valid || !out_stall);
  assign room  = (pat_len != LW'(PATTERN_MAX));
  assign hit   = active[pat_len];

  // Step every live position on the text byte.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      keep_bits[i] = active[i] && vmask[i] && star_bits[i];
      move_bits[i] = active[i] && vmask[i] && !star_bits[i] &&
                     (any_bits[i] || (byte_store[i] == q_cmd.code));
    end
  end

  // Parallel prefix closure along runs of '*' cells.
  always_comb begin
    gen_v[0]     = {1'b0, keep_bits} | {move_bits, 1'b0};
    prop_v[0][0] = 1'b0;
    for (int j = 1; j <= PATTERN_MAX; j++) begin
      prop_v[0][j] = star_bits[j-1] && vmask[j-1];
    end
    for (int l = 0; l < LV; l++) begin
      for (int j = 0; j <= PATTERN_MAX; j++) begin
        if (j >= (1 << l)) begin
          gen_v[l+1][j]  = gen_v[l][j] || (prop_v[l][j] && gen_v[l][j-(1 << l)]);
          prop_v[l+1][j] = prop_v[l][j] && prop_v[l][j-(1 << l)];
        end else begin
          gen_v[l+1][j]  = gen_v[l][j];
          prop_v[l+1][j] = prop_v[l][j];
        end
      end
    end
    advanced = gen_v[LV];
  end

  // Restart set: position zero plus the leading run of '*' cells.
  always_comb begin
    restart_vec_next = restart_vec;
    if (q_pop) begin
      case (q_cmd.op)
        OP_CLEAR: restart_vec_next = (PATTERN_MAX + 1)'(1);
        OP_APPEND: begin
          if (room) restart_vec_next[pat_len + LW'(1)] = restart_vec[pat_len] && q_cmd.is_star;
        end
        default: restart_vec_next = restart_vec;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len     <= '0;
      ovf         <= 1'b0;
      vmask       <= '0;
      active      <= (PATTERN_MAX + 1)'(1);
      restart_vec <= (PATTERN_MAX + 1)'(1);
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        restart_vec <= restart_vec_next;
        case (q_cmd.op)
          OP_CLEAR: begin
            pat_len <= '0;
            ovf     <= 1'b0;
            vmask   <= '0;
            active  <= restart_vec_next;
          end
          OP_APPEND: begin
            if (room) begin
              pat_len                 <= pat_len + LW'(1);
              vmask[pat_len[IW-1:0]]  <= 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            active <= restart_vec_next;
          end
          OP_TEXT:  active <= advanced;
          OP_END:   active <= restart_vec_next;
          default:  active <= active;
        endcase
      end
      if (q_pop && (q_cmd.op == OP_END)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == OP_APPEND) && room) begin
      byte_store[pat_len[IW-1:0]] <= q_cmd.code;
      star_bits[pat_len[IW-1:0]]  <= q_cmd.is_star;
      any_bits[pat_len[IW-1:0]]   <= q_cmd.is_any;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == OP_END)) begin
      matched  <= hit && !ovf;
      overflow <= ovf;
    end
  end

endmodule

FILE: verif/tb_glob_wildcard_matcher.sv
`timescale 1ns / 100ps
// Self-checking testbench for the glob wildcard matcher: pattern loads and text streams.
module tb_glob_wildcard_matcher;
  import gwm_pkg::*;

  localparam int PMAX        = PATTERN_MAX_DEFAULT;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 500;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] mode;
  logic [7:0] char_code;
  logic       out_valid;
  logic       out_stall;
  logic       matched;
  logic       overflow;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  // Tracks the pattern and the live position set, and holds the verdicts still owed.
  class glob_scoreboard;
    logic [7:0]    pat_bytes[PMAX];
    int unsigned   pat_len;
    logic [PMAX:0] live;
    logic          ovf;
    verdict_t      verdict_q[$];
    int            failures;
    int            reported;

    function new();
      pat_len  = 0;
      ovf      = 1'b0;
      failures = 0;
      reported = 0;
      restart_live();
    endfunction

    // A live '*' also makes the next position live (empty run).
    function void close_live();
      for (int i = 0; i < pat_len; i++) begin
        if (live[i] && pat_bytes[i] == SYM_ANY_RUN) live[i+1] = 1'b1;
      end
    endfunction

    function void restart_live();
      live    = '0;
      live[0] = 1'b1;
      close_live();
    endfunction

    function void step_text(logic [7:0] c);
      logic [PMAX:0] nxt;
      nxt = '0;
      for (int i = 0; i < pat_len; i++) begin
        if (live[i]) begin
          if (pat_bytes[i] == SYM_ANY_RUN) nxt[i] = 1'b1;
          else if (pat_bytes[i] == SYM_ANY_ONE || pat_bytes[i] == c) nxt[i+1] = 1'b1;
        end
      end
      live = nxt;
      close_live();
    endfunction

    function void note_transfer(logic [1:0] m, logic [7:0] c);
      verdict_t v;
      case (m)
        MODE_CLEAR: begin
          pat_len = 0;
          ovf     = 1'b0;
          restart_live();
        end
        MODE_APPEND: begin
          if (pat_len < PMAX) begin
            pat_bytes[pat_len] = c;
            pat_len++;
          end else begin
            ovf = 1'b1;
          end
          restart_live();
        end
        MODE_TEXT: step_text(c);
        default: begin
          v.matched  = live[pat_len] && !ovf;
          v.overflow = ovf;
          verdict_q.push_back(v);
          restart_live();
        end
      endcase
    endfunction

    function void check_verdict(logic m, logic o);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("%0t: unexpected result matched=%0b overflow=%0b", $realtime, m, o);
        end
      end else begin
        want = verdict_q.pop_front();
        if (want.matched !== m || want.overflow !== o) begin
          failures++;
          if (reported < 10) begin
            reported++;
            $display("%0t: mismatch matched exp %0b got %0b, overflow exp %0b got %0b",
                     $realtime, want.matched, m, want.overflow, o);
          end
        end
      end
    endfunction

    function int outstanding();
      return verdict_q.size();
    endfunction
  endclass

  glob_scoreboard sb;

  glob_wildcard_matcher #(.PATTERN_MAX(PMAX)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .matched   (matched),
    .overflow  (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL glob_wildcard_matcher");
      $finish;
    end
  end

  // Result side: check every transfer on the output channel.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_verdict(matched, overflow);
  end

  // Receiver stall pattern, with one long hold-off on request.
  bit hold_req = 1'b0;
  initial begin
    int style;
    int left;
    int tick;
    style = 0;
    left  = 0;
    tick  = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left  = $urandom_range(20, 80);
        end
        left--;
        tick++;
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 25);
          2: out_stall <= ($urandom_range(0, 99) < 60);
          default: out_stall <= (tick % 3 != 0);
        endcase
      end
    end
  end

  // Sender: items come in bursts of random length separated by random gaps.
  int items_sent = 0;
  int burst_left = 0;
  logic [7:0] cur_pat[$];

  task automatic send_item(logic [1:0] m, logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    mode      <= m;
    char_code <= c;
    do @(posedge clk); while (in_stall);
    sb.note_transfer(m, c);
    items_sent++;
  endtask

  // Hold the input idle until every owed verdict has come out.
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(bit full_range, bit for_text);
    if (full_range) return 8'($urandom_range(0, 255));
    if (for_text) begin
      case ($urandom_range(0, 3))
        0: return "a";
        1: return "b";
        2: return "c";
        default: return 8'h00;
      endcase
    end
    case ($urandom_range(0, 5))
      0, 1: return "a";
      2: return "b";
      3: return SYM_ANY_RUN;
      4: return SYM_ANY_ONE;
      default: return 8'h00;
    endcase
  endfunction

  task automatic load_pattern(int len, bit full_range);
    logic [7:0] b;
    send_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
    cur_pat.delete();
    for (int i = 0; i < len; i++) begin
      b = pick_byte(full_range, 1'b0);
      cur_pat.push_back(b);
      send_item(MODE_APPEND, b);
    end
  endtask

  // Build a text aimed at the current pattern (or random), stream it, close it.
  task automatic send_text_and_end(bit aim_match, bit full_range);
    logic [7:0] txt[$];
    int k;
    if (aim_match) begin
      foreach (cur_pat[i]) begin
        if (cur_pat[i] == SYM_ANY_RUN) begin
          k = $urandom_range(0, 3);
          repeat (k) txt.push_back(pick_byte(full_range, 1'b1));
        end else if (cur_pat[i] == SYM_ANY_ONE) begin
          txt.push_back(pick_byte(full_range, 1'b1));
        end else begin
          txt.push_back(cur_pat[i]);
        end
      end
      if (txt.size() > 0 && $urandom_range(0, 4) == 0)
        txt[$urandom_range(0, txt.size() - 1)] = pick_byte(full_range, 1'b1);
    end else begin
      k = $urandom_range(0, 8);
      repeat (k) txt.push_back(pick_byte(full_range, 1'b1));
    end
    foreach (txt[i]) send_item(MODE_TEXT, txt[i]);
    send_item(MODE_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int r;
    int start_count;
    bit full_range;
    bit held;
    bit drained;
    rst       = 1'b1;
    in_valid  = 1'b0;
    mode      = MODE_CLEAR;
    char_code = 8'h00;
    sb        = new();
    full_range = 1'b0;
    held       = 1'b0;
    drained    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty pattern against empty and non-empty text.
    send_item(MODE_END, 8'h00);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_END, 8'hFF);
    // Lone star takes anything, a literal star in the text included.
    send_item(MODE_APPEND, SYM_ANY_RUN);
    send_item(MODE_END, 8'h00);
    send_item(MODE_TEXT, 8'hFF);
    send_item(MODE_TEXT, SYM_ANY_RUN);
    send_item(MODE_END, 8'h00);
    // Zero byte and '?' in the pattern.
    send_item(MODE_CLEAR, 8'hFF);
    send_item(MODE_APPEND, 8'h00);
    send_item(MODE_APPEND, SYM_ANY_ONE);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_TEXT, 8'h7E);
    send_item(MODE_END, 8'h55);
    send_item(MODE_TEXT, 8'h01);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_END, 8'hAA);
    // Append without a clear restarts the set; star in the middle.
    send_item(MODE_APPEND, SYM_ANY_RUN);
    send_item(MODE_APPEND, 8'h80);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_TEXT, "q");
    send_item(MODE_TEXT, "z");
    send_item(MODE_TEXT, 8'h80);
    send_item(MODE_END, 8'h0F);
    cur_pat = '{8'h00, SYM_ANY_ONE, SYM_ANY_RUN, 8'h80};

    // Start the random part with a pattern that overflows the store.
    start_count = items_sent;
    load_pattern(PMAX + 2, 1'b0);
    send_text_and_end(1'b1, 1'b0);
    send_text_and_end(1'b0, 1'b0);

    while (items_sent - start_count < RANDOM_ITEMS) begin
      if (!held && items_sent - start_count > 180) begin
        // Stop draining results and keep offering items so the input backs up.
        held = 1'b1;
        hold_req = 1'b1;
        repeat (8) send_item(MODE_END, 8'($urandom_range(0, 255)));
      end
      if (!drained && items_sent - start_count > 340) begin
        drained = 1'b1;
        wait_all_results();
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        full_range = ($urandom_range(0, 4) < 2);
        if ($urandom_range(0, 9) == 0) load_pattern($urandom_range(PMAX - 2, PMAX + 4), full_range);
        else load_pattern($urandom_range(0, 6), full_range);
      end else if (r < 80) begin
        send_text_and_end($urandom_range(0, 9) < 7, full_range);
      end else if (r < 88) begin
        cur_pat.push_back(pick_byte(full_range, 1'b0));
        send_item(MODE_APPEND, cur_pat[$]);
      end else if (r < 94) begin
        repeat ($urandom_range(1, 3)) send_item(MODE_TEXT, pick_byte(full_range, 1'b1));
      end else begin
        r = $urandom_range(0, 3);
        if (r == MODE_CLEAR) begin
          cur_pat.delete();
          send_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
        end else if (r == MODE_APPEND) begin
          cur_pat.push_back(8'($urandom_range(0, 255)));
          send_item(MODE_APPEND, cur_pat[$]);
        end else if (r == MODE_TEXT) begin
          send_item(MODE_TEXT, 8'($urandom_range(0, 255)));
        end else begin
          send_item(MODE_END, 8'($urandom_range(0, 255)));
        end
      end
    end

    wait_all_results();
    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("PASS glob_wildcard_matcher");
    end else begin
      $display("FAIL glob_wildcard_matcher");
    end
    $finish;
  end

endmodule
